// ----- rtl/ppcem_pkg.sv -----
// ppcem_pkg: shared types, constants and the microcode table of the
// peak-to-peak current energy meter. No dependencies.
package ppcem_pkg;

    typedef logic [2:0] step_t;
    typedef logic [1:0] cond_t;
    typedef logic [1:0] cfg_idx_t;

    // Program steps
    localparam step_t STEP_FETCH  = 3'd0;
    localparam step_t STEP_UPDATE = 3'd1;
    localparam step_t STEP_SPAN   = 3'd2;
    localparam step_t STEP_GAIN   = 3'd3;
    localparam step_t STEP_CUR    = 3'd4;
    localparam step_t STEP_POWER  = 3'd5;
    localparam step_t STEP_ENERGY = 3'd6;
    localparam step_t STEP_EMIT   = 3'd7;

    // Jump conditions: jump to target when true, else fall through
    localparam cond_t COND_NONE     = 2'd0;
    localparam cond_t COND_NO_INPUT = 2'd1;
    localparam cond_t COND_NOT_END  = 2'd2;
    localparam cond_t COND_OUT_BUSY = 2'd3;

    // Configuration register indexes
    localparam cfg_idx_t REG_SAMPLES_PER_WINDOW = 2'd0;
    localparam cfg_idx_t REG_CURRENT_GAIN       = 2'd1;
    localparam cfg_idx_t REG_LINE_VOLTAGE       = 2'd2;

    localparam int SPW_BITS   = 16;
    localparam int GAIN_BITS  = 24;
    localparam int VOLT_BITS  = 9;
    localparam int CUR_BITS   = 16;
    localparam int PWR_BITS   = 25;
    localparam int EN_BITS    = 48;

    localparam logic [SPW_BITS-1:0]  SPW_RESET  = 16'd400;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd185;
    localparam logic [VOLT_BITS-1:0] VOLT_RESET = 9'd230;

    localparam logic [CUR_BITS-1:0] CURRENT_MAX = 16'hFFFF;
    localparam logic [EN_BITS-1:0]  ENERGY_MAX  = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic  accept;
        logic  upd_peak;
        logic  ld_span;
        logic  ld_prod;
        logic  ld_cur;
        logic  ld_pwr;
        logic  ld_energy;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic win_end;
        logic out_busy;
    } flags_t;

    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t w;
        w = '0;
        unique case (s)
            STEP_FETCH:
            begin
                w.accept = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = STEP_FETCH;
            end
            STEP_UPDATE:
            begin
                w.upd_peak = 1'b1;
                w.cond     = COND_NOT_END;
                w.target   = STEP_FETCH;
            end
            STEP_SPAN:   w.ld_span   = 1'b1;
            STEP_GAIN:   w.ld_prod   = 1'b1;
            STEP_CUR:    w.ld_cur    = 1'b1;
            STEP_POWER:  w.ld_pwr    = 1'b1;
            STEP_ENERGY: w.ld_energy = 1'b1;
            STEP_EMIT:
            begin
                // falls through to step 0 by wrap of the step counter
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/ppcem_sequencer.sv -----
// ppcem_sequencer: step counter and microcode fetch.
// Depends on ppcem_pkg.
module ppcem_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppcem_pkg::flags_t     flags,
    output ppcem_pkg::ctrl_word_t cw
);

    ppcem_pkg::step_t step_reg;
    ppcem_pkg::step_t step_next;
    logic             jump;

    assign cw = ppcem_pkg::ucode(step_reg);

    always_comb
    begin
        unique case (cw.cond)
            ppcem_pkg::COND_NONE:     jump = 1'b0;
            ppcem_pkg::COND_NO_INPUT: jump = !flags.in_valid;
            ppcem_pkg::COND_NOT_END:  jump = !flags.win_end;
            ppcem_pkg::COND_OUT_BUSY: jump = flags.out_busy;
        endcase
        step_next = jump ? cw.target : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ppcem_pkg::STEP_FETCH;
        else
            step_reg <= step_next;
    end

    a_no_end_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ppcem_pkg::STEP_UPDATE && !flags.win_end)
        |=> step_reg == ppcem_pkg::STEP_FETCH)
        else $error("window not ended but program continued");

    a_end_scales: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ppcem_pkg::STEP_UPDATE && flags.win_end)
        |=> step_reg == ppcem_pkg::STEP_SPAN)
        else $error("window end did not start scaling");

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ppcem_pkg::STEP_EMIT && flags.out_busy)
        |=> step_reg == ppcem_pkg::STEP_EMIT)
        else $error("emit step left while output busy");

endmodule

// ----- rtl/ppcem_datapath.sv -----
// ppcem_datapath: peak tracking, window count, scaling multipliers,
// energy accumulator and output register. Depends on ppcem_pkg.
module ppcem_datapath #(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppcem_pkg::ctrl_word_t                cw,
    input  logic                                 in_valid,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  logic [ppcem_pkg::SPW_BITS-1:0]       samples_per_window,
    input  logic [ppcem_pkg::GAIN_BITS-1:0]      current_gain,
    input  logic [ppcem_pkg::VOLT_BITS-1:0]      line_voltage,
    input  logic                                 out_ready,
    output ppcem_pkg::flags_t                    flags,
    output logic                                 out_valid,
    output logic [ppcem_pkg::CUR_BITS-1:0]       current_ma,
    output logic [ppcem_pkg::PWR_BITS-1:0]       power_mw,
    output logic [ppcem_pkg::EN_BITS-1:0]        energy_total
);

    localparam int PW = SAMPLE_BITS + ppcem_pkg::GAIN_BITS;

    logic [SAMPLE_BITS-1:0]            sample_reg;
    logic [SAMPLE_BITS-1:0]            peak_high_reg;
    logic [SAMPLE_BITS-1:0]            peak_low_reg;
    logic [ppcem_pkg::SPW_BITS-1:0]    count_reg;
    logic [ppcem_pkg::SPW_BITS-1:0]    count_next;
    logic [SAMPLE_BITS-1:0]            span_reg;
    logic [PW-1:0]                     prod_reg;
    logic [ppcem_pkg::CUR_BITS-1:0]    cur_reg;
    logic [ppcem_pkg::PWR_BITS-1:0]    pwr_reg;
    logic [ppcem_pkg::EN_BITS-1:0]     energy_reg;
    logic [ppcem_pkg::EN_BITS:0]       energy_sum;
    logic [ppcem_pkg::CUR_BITS-1:0]    cur_sat;
    logic                              out_valid_reg;
    logic                              out_busy;
    logic                              emit_en;

    assign count_next = count_reg + 16'd1;
    assign out_busy   = out_valid_reg && !out_ready;
    assign emit_en    = cw.emit && !out_busy;

    // a wrapped count means the longest window has ended
    assign flags.in_valid = in_valid;
    assign flags.win_end  = (count_next == '0) || (count_next >= samples_per_window);
    assign flags.out_busy = out_busy;

    assign cur_sat = (prod_reg[PW-1:16] > (PW-16)'(ppcem_pkg::CURRENT_MAX))
                   ? ppcem_pkg::CURRENT_MAX : prod_reg[31:16];
    assign energy_sum = {1'b0, energy_reg} + (ppcem_pkg::EN_BITS+1)'(pwr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_high_reg <= '0;
            peak_low_reg  <= '1;
            count_reg     <= '0;
            energy_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cw.upd_peak)
            begin
                if (sample_reg > peak_high_reg)
                    peak_high_reg <= sample_reg;
                if (sample_reg < peak_low_reg)
                    peak_low_reg <= sample_reg;
                count_reg <= count_next;
            end
            else if (emit_en)
            begin
                peak_high_reg <= '0;
                peak_low_reg  <= '1;
                count_reg     <= '0;
            end
            if (cw.ld_energy)
                energy_reg <= energy_sum[ppcem_pkg::EN_BITS] ? ppcem_pkg::ENERGY_MAX
                                                             : energy_sum[ppcem_pkg::EN_BITS-1:0];
            if (emit_en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.accept && in_valid)
            sample_reg <= sample;
        if (cw.ld_span)
            span_reg <= (peak_high_reg >= peak_low_reg) ? peak_high_reg - peak_low_reg : '0;
        if (cw.ld_prod)
            prod_reg <= PW'(span_reg) * PW'(current_gain);
        if (cw.ld_cur)
            cur_reg <= cur_sat;
        // 16 x 9 bits cannot exceed the 25-bit power range
        if (cw.ld_pwr)
            pwr_reg <= ppcem_pkg::PWR_BITS'(cur_reg) * ppcem_pkg::PWR_BITS'(line_voltage);
        if (emit_en)
        begin
            current_ma   <= cur_reg;
            power_mw     <= pwr_reg;
            energy_total <= energy_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |=> out_valid_reg && count_reg == '0 && peak_high_reg == '0)
        else $error("emit did not load output and restart window");

    a_energy_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cw.ld_energy |=> energy_reg >= $past(energy_reg))
        else $error("energy total decreased");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> !(out_valid_reg && !out_ready))
        else $error("output overwritten while held");

endmodule

// ----- rtl/peak_to_peak_current_energy_meter.sv -----
// peak_to_peak_current_energy_meter: top level, configuration registers
// and stream packing. Depends on ppcem_pkg, ppcem_sequencer, ppcem_datapath.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  s_axis  | s_tvalid / s_tready    | s_tdata: sample
//  m_axis  | m_tvalid / m_tready    | m_tdata: current_ma, power_mw, energy
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item ending no window passes the fetch and update steps; one closing a
// window runs the whole microcode program from fetch to emit, and the emit
// step waits for the output register to drain. Reset clears the window,
// the energy total and the registers to their defaults. Configuration is
// always ready.
module peak_to_peak_current_energy_meter #(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample, zero pad
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [95:0]                           m_tdata,  // current_ma[15:0],
                                                            // power_mw[40:16],
                                                            // energy_total[88:41],
                                                            // zero pad
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  ppcem_pkg::cfg_idx_t                   cfg_index,
    input  logic [ppcem_pkg::GAIN_BITS-1:0]       cfg_data
);

    logic [ppcem_pkg::SPW_BITS-1:0]  spw_reg;
    logic [ppcem_pkg::GAIN_BITS-1:0] gain_reg;
    logic [ppcem_pkg::VOLT_BITS-1:0] volt_reg;

    ppcem_pkg::ctrl_word_t           cw;
    ppcem_pkg::flags_t               flags;
    logic [ppcem_pkg::CUR_BITS-1:0]  current_ma;
    logic [ppcem_pkg::PWR_BITS-1:0]  power_mw;
    logic [ppcem_pkg::EN_BITS-1:0]   energy_total;

    assign cfg_ready = 1'b1;
    assign s_tready  = cw.accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spw_reg  <= ppcem_pkg::SPW_RESET;
            gain_reg <= ppcem_pkg::GAIN_RESET;
            volt_reg <= ppcem_pkg::VOLT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ppcem_pkg::REG_SAMPLES_PER_WINDOW: spw_reg  <= cfg_data[ppcem_pkg::SPW_BITS-1:0];
                ppcem_pkg::REG_CURRENT_GAIN:       gain_reg <= cfg_data;
                ppcem_pkg::REG_LINE_VOLTAGE:       volt_reg <= cfg_data[ppcem_pkg::VOLT_BITS-1:0];
                default:                           ;
            endcase
        end
    end

    ppcem_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    ppcem_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cw                 (cw),
        .in_valid           (s_tvalid),
        .sample             (s_tdata[SAMPLE_BITS-1:0]),
        .samples_per_window (spw_reg),
        .current_gain       (gain_reg),
        .line_voltage       (volt_reg),
        .out_ready          (m_tready),
        .flags              (flags),
        .out_valid          (m_tvalid),
        .current_ma         (current_ma),
        .power_mw           (power_mw),
        .energy_total       (energy_total)
    );

    assign m_tdata = {7'd0, energy_total, power_mw, current_ma};

endmodule
